### rtl/ofa_pkg.sv
package ofa_pkg;

  // field and datapath widths
  localparam int BYTE_W  = 8;
  localparam int SCALE_W = 11;
  localparam int SUM_W   = 32;
  localparam int FAC_W   = SCALE_W + 1;
  localparam int COUNT_W = 16;
  localparam int DEN_W   = COUNT_W + 10;
  localparam int PROD_W  = SUM_W + FAC_W;
  localparam int FLOW_W  = 17;
  localparam int STEP_W  = 5;
  localparam int CFG_IDX_W = 2;

  // fixed point: gain is (1000 + scale) / 1000
  localparam logic signed [FAC_W-1:0] GAIN_ONE  = 12'sd1000;
  localparam logic [DEN_W-1:0]        DEN_SCALE = 26'd1000;

  // top quotient bit; a hit there means the magnitude is past the flow range
  localparam logic [STEP_W-1:0] STEP_TOP = 5'(FLOW_W);

  // saturation limits of the flow outputs
  localparam logic signed [FLOW_W-1:0] FLOW_MAX = 17'sd65535;
  localparam logic signed [FLOW_W-1:0] FLOW_MIN = -17'sd65536;
  localparam logic [FLOW_W-1:0]        MAG_POS_MAX = 17'd65535;
  localparam logic [FLOW_W-1:0]        MAG_NEG_MAX = 17'd65536;
  localparam logic [COUNT_W-1:0]       COUNT_MAX = 16'hFFFF;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 2'd3;

  // register reset values
  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd254;
  localparam logic [BYTE_W-1:0] FOOTER_RESET = 8'd170;

  // running window totals from the frame parser
  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [COUNT_W-1:0]      count;
  } acc_t;

  // request to the shared scale and divide unit
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sum;
    logic signed [FAC_W-1:0] factor;
    logic [DEN_W-1:0]        den;
  } div_req_t;

  // reply of the shared scale and divide unit
  typedef struct packed {
    logic                     done;
    logic signed [FLOW_W-1:0] flow;
  } div_rsp_t;

endpackage

### rtl/optical_flow_frame_averager_core.sv
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+-------------------------------------------
// in       | to core   | in_valid / in_ready    | action, rx_byte
// out      | from core | out_valid / out_ready  | flow_x, flow_y, frames_in_window, no_frames
// cfg      | to core   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// byte item: the core stays idle for the next item; window-end item: per axis a load,
// a multiply, trial subtracts from the top quotient bit down (cut short by a hit there)
// and a sign and saturation step, then a handoff to y and a load into the output register;
// an empty window goes straight to that load. The result waits there; bytes are taken
// meanwhile; a later window-end item holds in its last state until the register is free
// synchronous active-high reset; no clearing pass; cfg_ready is always high
module optical_flow_frame_averager_core #(
  parameter int FRAME_LENGTH = 9
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 action,
  input  logic [ofa_pkg::BYTE_W-1:0]           rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ofa_pkg::FLOW_W-1:0]    flow_x,
  output logic signed [ofa_pkg::FLOW_W-1:0]    flow_y,
  output logic [ofa_pkg::COUNT_W-1:0]          frames_in_window,
  output logic                                 no_frames,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ofa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ofa_pkg::SCALE_W-1:0]          cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN_X = 2'd1;
  localparam logic [1:0] S_RUN_Y = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [ofa_pkg::BYTE_W-1:0]  header_byte;
  logic [ofa_pkg::BYTE_W-1:0]  footer_byte;
  logic [ofa_pkg::SCALE_W-1:0] scale_x;
  logic [ofa_pkg::SCALE_W-1:0] scale_y;
  logic signed [ofa_pkg::FLOW_W-1:0] res_x;
  logic signed [ofa_pkg::FLOW_W-1:0] res_y;

  ofa_pkg::acc_t     acc;
  ofa_pkg::div_req_t req;
  ofa_pkg::div_rsp_t rsp;

  logic in_fire;
  logic byte_en;
  logic win_fire;
  logic out_free;
  logic finish;
  logic [ofa_pkg::SCALE_W-1:0] scale_sel;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign byte_en   = in_fire && !action;
  assign win_fire  = in_fire && action;
  assign out_free  = !out_valid || out_ready;
  assign finish    = (state == S_DONE) && out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= ofa_pkg::HEADER_RESET;
      footer_byte <= ofa_pkg::FOOTER_RESET;
      scale_x     <= '0;
      scale_y     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ofa_pkg::REG_HEADER:  header_byte <= cfg_data[ofa_pkg::BYTE_W-1:0];
        ofa_pkg::REG_FOOTER:  footer_byte <= cfg_data[ofa_pkg::BYTE_W-1:0];
        ofa_pkg::REG_SCALE_X: scale_x     <= cfg_data;
        ofa_pkg::REG_SCALE_Y: scale_y     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // frame collection and window totals
  ofa_parser #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .byte_en     (byte_en),
    .rx_byte     (rx_byte),
    .header_byte (header_byte),
    .footer_byte (footer_byte),
    .clear       (finish),
    .acc         (acc)
  );

  // operands of the shared unit: x is started from idle, y after x completes
  assign scale_sel  = (state == S_IDLE) ? scale_x : scale_y;
  assign req.start  = (win_fire && acc.count != '0) || (state == S_RUN_X && rsp.done);
  assign req.sum    = (state == S_IDLE) ? acc.sum_x : acc.sum_y;
  assign req.factor = $signed({scale_sel[ofa_pkg::SCALE_W-1], scale_sel}) + ofa_pkg::GAIN_ONE;
  assign req.den    = ofa_pkg::DEN_W'(acc.count) * ofa_pkg::DEN_SCALE;

  ofa_scale_div u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // window sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (win_fire) begin
            state <= (acc.count != '0) ? S_RUN_X : S_DONE;
          end
        end
        S_RUN_X: begin
          if (rsp.done) begin
            state <= S_RUN_Y;
          end
        end
        S_RUN_Y: begin
          if (rsp.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // per-axis results
  always_ff @(posedge clk) begin
    if (win_fire && acc.count == '0) begin
      res_x <= '0;
      res_y <= '0;
    end else if (state == S_RUN_X && rsp.done) begin
      res_x <= rsp.flow;
    end else if (state == S_RUN_Y && rsp.done) begin
      res_y <= rsp.flow;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      flow_x           <= res_x;
      flow_y           <= res_y;
      frames_in_window <= acc.count;
      no_frames        <= (acc.count == '0);
    end
  end

endmodule

### rtl/ofa_parser.sv
module ofa_parser #(
  parameter int FRAME_LENGTH = 9
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       byte_en,
  input  logic [ofa_pkg::BYTE_W-1:0] rx_byte,
  input  logic [ofa_pkg::BYTE_W-1:0] header_byte,
  input  logic [ofa_pkg::BYTE_W-1:0] footer_byte,
  input  logic                       clear,
  output ofa_pkg::acc_t              acc
);

  localparam int FILL_W = $clog2(FRAME_LENGTH);
  localparam logic [FILL_W-1:0] LAST_POS = FILL_W'(FRAME_LENGTH - 1);
  localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);

  logic [ofa_pkg::BYTE_W-1:0] frame_bytes [FRAME_LENGTH];
  logic [FILL_W-1:0]          fill_level;
  logic signed [ofa_pkg::SUM_W-1:0] sum_x;
  logic signed [ofa_pkg::SUM_W-1:0] sum_y;
  logic [ofa_pkg::COUNT_W-1:0]      frame_count;

  logic signed [ofa_pkg::SUM_W-1:0] dx;
  logic signed [ofa_pkg::SUM_W-1:0] dy;
  logic                             frame_ok;

  // little-endian signed flow words of the frame being closed
  assign dx = {{(ofa_pkg::SUM_W - 16){frame_bytes[3][7]}}, frame_bytes[3], frame_bytes[2]};
  assign dy = {{(ofa_pkg::SUM_W - 16){frame_bytes[5][7]}}, frame_bytes[5], frame_bytes[4]};

  // last byte of a frame with a good footer and room in the count
  assign frame_ok = byte_en && (fill_level == LAST_POS) && (rx_byte == footer_byte)
                    && (frame_count != ofa_pkg::COUNT_MAX);

  // frame byte store
  always_ff @(posedge clk) begin
    if (byte_en && (fill_level != '0 || rx_byte == header_byte)) begin
      frame_bytes[fill_level] <= rx_byte;
    end
  end

  // frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_level <= '0;
    end else if (byte_en) begin
      if (fill_level == '0) begin
        if (rx_byte == header_byte) begin
          fill_level <= FILL_ONE;
        end
      end else if (fill_level == LAST_POS) begin
        fill_level <= '0;
      end else begin
        fill_level <= fill_level + FILL_ONE;
      end
    end
  end

  // window totals
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sum_x       <= '0;
      sum_y       <= '0;
      frame_count <= '0;
    end else if (frame_ok) begin
      sum_x       <= sum_x + dx;
      sum_y       <= sum_y + dy;
      frame_count <= frame_count + 16'd1;
    end
  end

  assign acc.sum_x = sum_x;
  assign acc.sum_y = sum_y;
  assign acc.count = frame_count;

endmodule

### rtl/ofa_scale_div.sv
module ofa_scale_div (
  input  logic              clk,
  input  logic              rst,
  input  ofa_pkg::div_req_t req,
  output ofa_pkg::div_rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam int PW = ofa_pkg::PROD_W;
  localparam int QW = ofa_pkg::FLOW_W;

  logic [1:0] state;
  logic signed [ofa_pkg::SUM_W-1:0] op_sum;
  logic signed [ofa_pkg::FAC_W-1:0] op_fac;
  logic [ofa_pkg::DEN_W-1:0]        den;
  logic [PW-1:0]                    rem;
  logic [PW-1:0]                    dsh;
  logic [QW-1:0]                    quo;
  logic [ofa_pkg::STEP_W-1:0]       step;
  logic                             neg;
  logic                             big;
  logic                             done;
  logic signed [QW-1:0]             flow;

  logic signed [PW-1:0] prod;
  logic [PW:0]          diff;
  logic                 ge;
  logic signed [QW-1:0] flow_next;

  // scaled numerator and the shared trial subtract
  assign prod = op_sum * op_fac;
  assign diff = {1'b0, rem} - {1'b0, dsh};
  assign ge   = !diff[PW];

  // sign and saturation of the quotient
  always_comb begin
    if (big) begin
      flow_next = neg ? ofa_pkg::FLOW_MIN : ofa_pkg::FLOW_MAX;
    end else if (!neg) begin
      flow_next = (quo > ofa_pkg::MAG_POS_MAX) ? ofa_pkg::FLOW_MAX : $signed(quo);
    end else begin
      flow_next = (quo > ofa_pkg::MAG_NEG_MAX) ? ofa_pkg::FLOW_MIN : $signed(~quo + 17'd1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if ((step == ofa_pkg::STEP_TOP && ge) || step == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req.start) begin
          op_sum <= req.sum;
          op_fac <= req.factor;
          den    <= req.den;
        end
      end
      S_MUL: begin
        neg  <= prod[PW-1];
        rem  <= prod[PW-1] ? PW'(-prod) : PW'(prod);
        dsh  <= PW'({den, {QW{1'b0}}});
        step <= ofa_pkg::STEP_TOP;
        quo  <= '0;
        big  <= 1'b0;
      end
      S_DIV: begin
        if (step == ofa_pkg::STEP_TOP) begin
          big <= ge;
        end else begin
          quo <= {quo[QW-2:0], ge};
        end
        if (ge) begin
          rem <= diff[PW-1:0];
        end
        dsh  <= dsh >> 1;
        step <= step - 5'd1;
      end
      S_FIN: begin
        flow <= flow_next;
      end
      default: begin
      end
    endcase
  end

  assign rsp.done = done;
  assign rsp.flow = flow;

endmodule
